@@ rtl/dpec_pkg.sv @@
// Shared types, widths and pipeline latencies of the disc pair collision core.
package dpec_pkg;

    localparam int POS_W    = 18;
    localparam int RAD_W    = 12;
    localparam int CD_W     = 17;
    localparam int DIFF_W   = POS_W + 1;
    localparam int SUM_W    = RAD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SQ_W     = PROD_W;
    localparam int S_W      = 2 * CD_W;
    localparam int K_W      = PROD_W + 1;
    localparam int KX_W     = K_W + DIFF_W;
    localparam int ROOT_W   = S_W / 2;
    localparam int VQ_W     = 20;
    localparam int PQ_W     = 15;
    localparam int OV_W     = ROOT_W + 1;
    localparam int OVX_W    = OV_W + DIFF_W;
    localparam int PDEN_W   = ROOT_W + 1;
    localparam int EX_W     = VQ_W + 1;
    localparam int PX_W     = PQ_W + 1;
    localparam int IN_W     = 8 * POS_W + 2 * RAD_W;
    localparam int OUT_W    = 8 * POS_W;

    localparam logic [CD_W-1:0] CD_RESET = 17'd3840;

    localparam int FRONT_LAT = 4;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int VDIV_LAT  = VQ_W + 2;
    localparam int PDIV_LAT  = PQ_W + 2;
    localparam int PUSH_LAT  = SQRT_LAT + 1 + PDIV_LAT;
    localparam int EX_DLY    = PUSH_LAT - VDIV_LAT;
    localparam int TOTAL_LAT = FRONT_LAT + PUSH_LAT + 1;

    typedef struct packed {
        logic        [RAD_W-1:0] second_radius;
        logic signed [POS_W-1:0] second_vy;
        logic signed [POS_W-1:0] second_vx;
        logic signed [POS_W-1:0] second_y;
        logic signed [POS_W-1:0] second_x;
        logic        [RAD_W-1:0] first_radius;
        logic signed [POS_W-1:0] first_vy;
        logic signed [POS_W-1:0] first_vx;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] first_x;
    } t_pair;

    typedef struct packed {
        t_pair                    pair;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic        [SUM_W-1:0]  rs;
        logic        [S_W-1:0]    s;
        logic signed [KX_W-1:0]   kx;
        logic signed [KX_W-1:0]   ky;
        logic                     hit;
        logic                     push;
    } t_front;

    typedef struct packed {
        t_pair pair;
        logic  hit;
        logic  push;
    } t_side;

endpackage

@@ rtl/dpec_delay.sv @@
// Clock-enabled delay line that keeps side data aligned with the arithmetic units.
module dpec_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_tap [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_tap[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

@@ rtl/dpec_front.sv @@
// Front stages: differences, products, distance test and the numerators of the velocity change.
module dpec_front
    import dpec_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_ce,
    input  t_pair           i_pair,
    input  logic [CD_W-1:0] i_cd,
    output t_front          o_front
);

    typedef struct packed {
        t_pair                    pair;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dvx;
        logic signed [DIFF_W-1:0] dvy;
        logic        [SUM_W-1:0]  rs;
    } t_s1;

    typedef struct packed {
        t_pair                    pair;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic        [SUM_W-1:0]  rs;
        logic signed [PROD_W-1:0] dxx;
        logic signed [PROD_W-1:0] dyy;
        logic signed [PROD_W-1:0] kxp;
        logic signed [PROD_W-1:0] kyp;
        logic        [2*SUM_W-1:0] rs2;
        logic        [S_W-1:0]    cd2;
    } t_s2;

    typedef struct packed {
        t_pair                    pair;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic        [SUM_W-1:0]  rs;
        logic        [SQ_W-1:0]   s;
        logic signed [K_W-1:0]    k;
        logic                     hit;
        logic                     push;
    } t_s3;

    t_s1 r_s1;
    t_s2 r_s2;
    t_s3 r_s3;
    t_front r_s4;

    logic [SQ_W-1:0] w_s;
    logic            w_hit;

    assign w_s   = $unsigned(r_s2.dxx) + $unsigned(r_s2.dyy);
    assign w_hit = (w_s != '0) && (w_s < SQ_W'(r_s2.cd2));

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1.pair <= i_pair;
            r_s1.dx   <= DIFF_W'(i_pair.second_x) - DIFF_W'(i_pair.first_x);
            r_s1.dy   <= DIFF_W'(i_pair.second_y) - DIFF_W'(i_pair.first_y);
            r_s1.dvx  <= DIFF_W'(i_pair.second_vx) - DIFF_W'(i_pair.first_vx);
            r_s1.dvy  <= DIFF_W'(i_pair.second_vy) - DIFF_W'(i_pair.first_vy);
            r_s1.rs   <= SUM_W'(i_pair.first_radius) + SUM_W'(i_pair.second_radius);

            r_s2.pair <= r_s1.pair;
            r_s2.dx   <= r_s1.dx;
            r_s2.dy   <= r_s1.dy;
            r_s2.rs   <= r_s1.rs;
            r_s2.dxx  <= r_s1.dx * r_s1.dx;
            r_s2.dyy  <= r_s1.dy * r_s1.dy;
            r_s2.kxp  <= r_s1.dvx * r_s1.dx;
            r_s2.kyp  <= r_s1.dvy * r_s1.dy;
            r_s2.rs2  <= r_s1.rs * r_s1.rs;
            r_s2.cd2  <= i_cd * i_cd;

            r_s3.pair <= r_s2.pair;
            r_s3.dx   <= r_s2.dx;
            r_s3.dy   <= r_s2.dy;
            r_s3.rs   <= r_s2.rs;
            r_s3.s    <= w_s;
            r_s3.k    <= r_s2.kxp + r_s2.kyp;
            r_s3.hit  <= w_hit;
            r_s3.push <= w_hit && (SQ_W'(r_s2.rs2) > w_s);

            r_s4.pair <= r_s3.pair;
            r_s4.dx   <= r_s3.dx;
            r_s4.dy   <= r_s3.dy;
            r_s4.rs   <= r_s3.rs;
            r_s4.s    <= r_s3.s[S_W-1:0];
            r_s4.kx   <= r_s3.k * r_s3.dx;
            r_s4.ky   <= r_s3.k * r_s3.dy;
            r_s4.hit  <= r_s3.hit;
            r_s4.push <= r_s3.push;
        end
    end

    assign o_front = r_s4;

endmodule

@@ rtl/dpec_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module dpec_sqrt #(
    parameter int IN_W = 34
) (
    input  logic              i_clk,
    input  logic              i_ce,
    input  logic [IN_W-1:0]   i_val,
    output logic [IN_W/2-1:0] o_root
);

    localparam int R_W = IN_W / 2;

    logic [IN_W-1:0] r_v   [0:R_W-1];
    logic [IN_W:0]   r_res [0:R_W-1];

    for (genvar j = 0; j < R_W; j++) begin : g_stage
        localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (2 * (R_W - 1 - j));
        logic [IN_W-1:0] w_vin;
        logic [IN_W:0]   w_rin;
        logic [IN_W:0]   w_trial;
        logic            w_ge;

        if (j == 0) begin : g_first
            assign w_vin = i_val;
            assign w_rin = '0;
        end else begin : g_next
            assign w_vin = r_v[j-1];
            assign w_rin = r_res[j-1];
        end

        assign w_trial = w_rin + BIT;
        assign w_ge    = {1'b0, w_vin} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_v[j]   <= w_ge ? IN_W'({1'b0, w_vin} - w_trial) : w_vin;
                r_res[j] <= w_ge ? (w_rin >> 1) + BIT : w_rin >> 1;
            end
        end
    end

    assign o_root = r_res[R_W-1][R_W-1:0];

endmodule

@@ rtl/dpec_div.sv @@
// Pipelined signed by unsigned division, rounded to nearest with ties away from zero.
module dpec_div #(
    parameter int NUM_W = 58,
    parameter int DEN_W = 34,
    parameter int Q_W   = 20
) (
    input  logic                    i_clk,
    input  logic                    i_ce,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic signed [Q_W:0]     o_quo
);

    localparam int M_W = NUM_W + 1;
    localparam int C_W = (M_W > DEN_W + Q_W) ? M_W : DEN_W + Q_W;

    logic [NUM_W-1:0] w_mag;
    logic [M_W-1:0]   r_m   [0:Q_W-1];
    logic [DEN_W-1:0] r_den [0:Q_W-1];
    logic             r_neg [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic signed [Q_W:0] r_quo;

    assign w_mag = i_num[NUM_W-1] ? ~$unsigned(i_num) + NUM_W'(1) : $unsigned(i_num);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m[0]   <= M_W'(w_mag) + M_W'(i_den >> 1);
            r_den[0] <= i_den;
            r_neg[0] <= i_num[NUM_W-1];
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_bit
        localparam int SH = Q_W - 1 - j;
        logic [C_W-1:0] w_d;
        logic           w_ge;

        assign w_d  = C_W'(r_den[j]) << SH;
        assign w_ge = C_W'(r_m[j]) >= w_d;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[j+1]   <= r_q[j] | (Q_W'(w_ge) << SH);
                r_neg[j+1] <= r_neg[j];
            end
        end

        if (j < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_m[j+1]   <= w_ge ? M_W'(C_W'(r_m[j]) - w_d) : r_m[j];
                    r_den[j+1] <= r_den[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_quo <= r_neg[Q_W] ? -$signed({1'b0, r_q[Q_W]}) : $signed({1'b0, r_q[Q_W]});
        end
    end

    assign o_quo = r_quo;

endmodule

@@ rtl/disc_pair_elastic_collision_core.sv @@
// Top level of the equal-mass elastic disc pair collision core.
// The core takes one disc pair per clock while the output is not stalled and returns each
// pair in order; most of the depth is the 17-stage square root of the squared
// centre distance followed by the 17-stage divider that forms the separation push.
// A stalled output freezes the whole pipeline, so every stage holds its request.
// The contact distance register may be written only while no request is in flight.
module disc_pair_elastic_collision_core
    import dpec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CD_W-1:0]  i_cfg_wr_data,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // first_x, first_y, first_vx, first_vy, first_radius,
    // second_x, second_y, second_vx, second_vy, second_radius
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // new_first_x, new_first_y, new_first_vx, new_first_vy,
    // new_second_x, new_second_y, new_second_vx, new_second_vy
    output logic [OUT_W-1:0] o_m_tdata,
    // collided
    output logic             o_m_tuser
);

    localparam int V_W = EX_W + 1;

    logic [CD_W-1:0]      r_cd;
    logic [TOTAL_LAT-1:0] r_valid;
    logic                 w_ce;

    t_pair  w_pair;
    t_front w_front;
    t_side  w_side_in;
    t_side  w_side;

    logic signed [EX_W-1:0]   w_ex;
    logic signed [EX_W-1:0]   w_ey;
    logic signed [EX_W-1:0]   w_ex_d;
    logic signed [EX_W-1:0]   w_ey_d;
    logic        [ROOT_W-1:0] w_root;
    logic signed [DIFF_W-1:0] w_dx_d;
    logic signed [DIFF_W-1:0] w_dy_d;
    logic        [SUM_W-1:0]  w_rs_d;
    logic signed [OV_W-1:0]   w_ov;
    logic signed [OVX_W-1:0]  r_ovx;
    logic signed [OVX_W-1:0]  r_ovy;
    logic        [PDEN_W-1:0] r_pden;
    logic signed [PX_W-1:0]   w_px;
    logic signed [PX_W-1:0]   w_py;

    logic signed [V_W-1:0]    w_vx1;
    logic signed [V_W-1:0]    w_vy1;
    logic signed [V_W-1:0]    w_vx2;
    logic signed [V_W-1:0]    w_vy2;
    logic signed [DIFF_W-1:0] w_x1;
    logic signed [DIFF_W-1:0] w_y1;
    logic signed [DIFF_W-1:0] w_x2;
    logic signed [DIFF_W-1:0] w_y2;

    logic [OUT_W-1:0] r_tdata;
    logic             r_tuser;

    function automatic logic signed [POS_W-1:0] sat(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] lo;
        hi = V_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
        lo = V_W'(signed'({1'b1, {(POS_W-1){1'b0}}}));
        if (v > hi) begin
            return POS_W'(hi);
        end else if (v < lo) begin
            return POS_W'(lo);
        end
        return POS_W'(v);
    endfunction

    assign w_ce       = !r_valid[TOTAL_LAT-1] || i_m_tready;
    assign o_s_tready = w_ce && i_rst_n;
    assign w_pair     = t_pair'(i_s_tdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd <= CD_RESET;
        end else if (i_cfg_wr_en) begin
            r_cd <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ce) begin
            r_valid <= {r_valid[TOTAL_LAT-2:0], i_s_tvalid};
        end
    end

    dpec_front u_front (
        .i_clk   (i_clk),
        .i_ce    (w_ce),
        .i_pair  (w_pair),
        .i_cd    (r_cd),
        .o_front (w_front)
    );

    dpec_div #(.NUM_W(KX_W), .DEN_W(S_W), .Q_W(VQ_W)) u_vdiv_x (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (w_front.kx),
        .i_den (w_front.s),
        .o_quo (w_ex)
    );

    dpec_div #(.NUM_W(KX_W), .DEN_W(S_W), .Q_W(VQ_W)) u_vdiv_y (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (w_front.ky),
        .i_den (w_front.s),
        .o_quo (w_ey)
    );

    dpec_delay #(.W(2 * EX_W), .DEPTH(EX_DLY)) u_ex_dly (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_data ({w_ex, w_ey}),
        .o_data ({w_ex_d, w_ey_d})
    );

    dpec_sqrt #(.IN_W(S_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_val  (w_front.s),
        .o_root (w_root)
    );

    dpec_delay #(.W(2 * DIFF_W + SUM_W), .DEPTH(SQRT_LAT)) u_geo_dly (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_data ({w_front.dx, w_front.dy, w_front.rs}),
        .o_data ({w_dx_d, w_dy_d, w_rs_d})
    );

    assign w_ov = $signed(OV_W'(w_rs_d)) - $signed({1'b0, w_root});

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ovx  <= w_ov * w_dx_d;
            r_ovy  <= w_ov * w_dy_d;
            r_pden <= {w_root, 1'b0};
        end
    end

    dpec_div #(.NUM_W(OVX_W), .DEN_W(PDEN_W), .Q_W(PQ_W)) u_pdiv_x (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r_ovx),
        .i_den (r_pden),
        .o_quo (w_px)
    );

    dpec_div #(.NUM_W(OVX_W), .DEN_W(PDEN_W), .Q_W(PQ_W)) u_pdiv_y (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r_ovy),
        .i_den (r_pden),
        .o_quo (w_py)
    );

    assign w_side_in.pair = w_front.pair;
    assign w_side_in.hit  = w_front.hit;
    assign w_side_in.push = w_front.push;

    dpec_delay #(.W($bits(t_side)), .DEPTH(PUSH_LAT)) u_side_dly (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_data (w_side_in),
        .o_data (w_side)
    );

    assign w_vx1 = V_W'(w_side.pair.first_vx)  + (w_side.hit ? V_W'(w_ex_d) : '0);
    assign w_vy1 = V_W'(w_side.pair.first_vy)  + (w_side.hit ? V_W'(w_ey_d) : '0);
    assign w_vx2 = V_W'(w_side.pair.second_vx) - (w_side.hit ? V_W'(w_ex_d) : '0);
    assign w_vy2 = V_W'(w_side.pair.second_vy) - (w_side.hit ? V_W'(w_ey_d) : '0);
    assign w_x1  = DIFF_W'(w_side.pair.first_x)  - (w_side.push ? DIFF_W'(w_px) : '0);
    assign w_y1  = DIFF_W'(w_side.pair.first_y)  - (w_side.push ? DIFF_W'(w_py) : '0);
    assign w_x2  = DIFF_W'(w_side.pair.second_x) + (w_side.push ? DIFF_W'(w_px) : '0);
    assign w_y2  = DIFF_W'(w_side.pair.second_y) + (w_side.push ? DIFF_W'(w_py) : '0);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_tdata <= {sat(w_vy2), sat(w_vx2), sat(V_W'(w_y2)), sat(V_W'(w_x2)),
                        sat(w_vy1), sat(w_vx1), sat(V_W'(w_y1)), sat(V_W'(w_x1))};
            r_tuser <= w_side.hit;
        end
    end

    assign o_m_tvalid = r_valid[TOTAL_LAT-1];
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

`ifndef SYNTHESIS
    a_push_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[TOTAL_LAT-2] && w_side.push |-> w_side.hit)
        else $error("Separation applied to a pair that did not collide.");

    a_ex_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[TOTAL_LAT-2] && w_side.hit |->
            (w_ex_d <= EX_W'(370721)) && (w_ex_d >= -EX_W'(370721)))
        else $error("Velocity change exceeds the relative velocity bound.");

    a_px_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[TOTAL_LAT-2] && w_side.push |->
            (w_px <= PX_W'(8191)) && (w_px >= -PX_W'(8191)))
        else $error("Separation push exceeds the radius sum bound.");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> $stable(r_valid))
        else $error("Pipeline valid bits moved during a stall.");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the disc pair elastic collision core.
module testbench
    import dpec_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [POS_W-1:0] second_vy;
        logic signed [POS_W-1:0] second_vx;
        logic signed [POS_W-1:0] second_y;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] first_vy;
        logic signed [POS_W-1:0] first_vx;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] first_x;
    } t_discs;

    typedef struct {
        t_discs discs;
        logic   collided;
    } t_outcome;

    class collision_scoreboard;
        logic [CD_W-1:0] contact_dist;
        t_outcome        pending[$];
        int              mismatches;

        function new();
            contact_dist = CD_RESET;
            mismatches = 0;
        endfunction

        static function automatic longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        static function automatic longint floor_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return longint'(res);
        endfunction

        static function automatic logic signed [POS_W-1:0] clamp(longint v);
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            return v[POS_W-1:0];
        endfunction

        function void note_request(t_pair p);
            longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, r1, r2;
            longint dx, dy, s, cd2, k, ex, ey, rs, len, ov, px, py;
            t_outcome o;
            x1 = longint'(p.first_x);   y1 = longint'(p.first_y);
            vx1 = longint'(p.first_vx); vy1 = longint'(p.first_vy);
            x2 = longint'(p.second_x);  y2 = longint'(p.second_y);
            vx2 = longint'(p.second_vx); vy2 = longint'(p.second_vy);
            r1 = longint'(p.first_radius);
            r2 = longint'(p.second_radius);
            dx = x2 - x1;
            dy = y2 - y1;
            s = dx * dx + dy * dy;
            cd2 = longint'(contact_dist) * longint'(contact_dist);
            o.collided = (s != 0) && (s < cd2);
            if (o.collided) begin
                k = (vx2 - vx1) * dx + (vy2 - vy1) * dy;
                ex = round_div(k * dx, s);
                ey = round_div(k * dy, s);
                vx1 += ex; vy1 += ey;
                vx2 -= ex; vy2 -= ey;
                rs = r1 + r2;
                if (rs * rs > s) begin
                    len = floor_sqrt(s);
                    ov = rs - len;
                    px = round_div(ov * dx, 2 * len);
                    py = round_div(ov * dy, 2 * len);
                    x2 += px; y2 += py;
                    x1 -= px; y1 -= py;
                end
            end
            o.discs.first_x = clamp(x1);   o.discs.first_y = clamp(y1);
            o.discs.first_vx = clamp(vx1); o.discs.first_vy = clamp(vy1);
            o.discs.second_x = clamp(x2);  o.discs.second_y = clamp(y2);
            o.discs.second_vx = clamp(vx2); o.discs.second_vy = clamp(vy2);
            pending.push_back(o);
        endfunction

        function void check_result(t_discs got, logic got_hit);
            t_outcome want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h collided %b", got, got_hit);
                return;
            end
            want = pending.pop_front();
            if (got !== want.discs || got_hit !== want.collided) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: first x/y/vx/vy exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             want.discs.first_x, want.discs.first_y, want.discs.first_vx,
                             want.discs.first_vy, got.first_x, got.first_y, got.first_vx,
                             got.first_vy);
                    $display("  second x/y/vx/vy exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             want.discs.second_x, want.discs.second_y, want.discs.second_vx,
                             want.discs.second_vy, got.second_x, got.second_y,
                             got.second_vx, got.second_vy);
                    $display("  collided exp %b got %b", want.collided, got_hit);
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CD_W-1:0]   i_cfg_wr_data;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;
    logic              o_m_tuser;

    collision_scoreboard sb;
    int results_seen;

    disc_pair_elastic_collision_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("disc_pair_elastic_collision_core verification failed");
        $finish;
    end

    // Receiver: changes its stall pattern now and then and holds off once for a long time.
    initial begin : receiver
        int mode;
        int hold;
        bit held;
        mode = 0;
        hold = 0;
        held = 0;
        results_seen = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                sb.check_result(t_discs'(o_m_tdata), o_m_tuser);
                results_seen++;
            end
            if (results_seen == 150 && !held) begin
                held = 1;
                hold = 300;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (mode == 0) begin
                i_m_tready <= 1'b1;
            end else if (mode == 1) begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end else begin
                i_m_tready <= ($urandom_range(0, 7) != 0);
            end
        end
    end

    int gap_left;
    int burst_left;

    task automatic send_pair(t_pair p);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= p;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        if (i_s_tvalid) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_contact(logic [CD_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.contact_dist = v;
        @(posedge i_clk);
    endtask

    function automatic t_pair make_pair(int fx, int fy, int fvx, int fvy, int fr,
                                        int sx, int sy, int svx, int svy, int sr);
        t_pair p;
        p.first_x = POS_W'(fx);   p.first_y = POS_W'(fy);
        p.first_vx = POS_W'(fvx); p.first_vy = POS_W'(fvy);
        p.first_radius = RAD_W'(fr);
        p.second_x = POS_W'(sx);   p.second_y = POS_W'(sy);
        p.second_vx = POS_W'(svx); p.second_vy = POS_W'(svy);
        p.second_radius = RAD_W'(sr);
        return p;
    endfunction

    function automatic t_pair random_pair(logic [CD_W-1:0] cd);
        t_pair p;
        int reach;
        p = t_pair'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        reach = (cd < 16) ? 16 : int'(cd);
        if ($urandom_range(0, 4) != 0) begin
            // Pair placed near contact so that most of them collide unless the contact distance is below 16.
            p.second_x = POS_W'(p.first_x + $signed($urandom_range(0, 2 * reach)) - reach);
            p.second_y = POS_W'(p.first_y + $signed($urandom_range(0, 2 * reach)) - reach);
            if ($urandom_range(0, 1)) begin
                p.first_radius = RAD_W'($urandom_range(0, cd / 2 < 4095 ? cd / 2 : 4095));
                p.second_radius = RAD_W'($urandom_range(0, cd / 2 < 4095 ? cd / 2 : 4095));
            end
        end
        return p;
    endfunction

    initial begin : stimulus
        logic [CD_W-1:0] settings[5];
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        burst_left = 0;
        gap_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs under the reset contact distance.
        send_pair(make_pair(100, 200, 64, -64, 640, 100, 200, -64, 64, 640));
        send_pair(make_pair(0, 0, 64, 0, 640, 3840, 0, -64, 0, 640));
        send_pair(make_pair(0, 0, 64, 0, 640, 3839, 0, -64, 0, 640));
        send_pair(make_pair(0, 0, 128, 32, 640, 1280, 0, -64, 16, 640));
        send_pair(make_pair(0, 0, 128, 32, 640, 1279, 0, -64, 16, 640));
        send_pair(make_pair(10, -20, 300, -77, 1000, 700, 900, -130, 55, 900));
        send_pair(make_pair(-131072, -131072, 131071, -131072, 4095,
                            -131070, -131071, -131072, 131071, 4095));
        send_pair(make_pair(131071, 131071, -131072, 131071, 4095,
                            131069, 131070, 131071, -131072, 4095));
        send_pair(make_pair(-131072, 131071, 0, 0, 0, 131071, -131072, 0, 0, 4095));
        send_pair(make_pair(5, 5, 131071, 131071, 4095, 6, 5, -131072, -131072, 0));
        send_pair(make_pair(0, 0, 131071, -131072, 3000, 3, 4, -131072, 131071, 3000));
        drain();

        settings[0] = '1;
        settings[1] = '0;
        settings[2] = 17'd1;
        settings[3] = 17'd200;
        settings[4] = CD_W'($urandom_range(1000, 60000));
        write_contact(settings[0]);
        send_pair(make_pair(-65536, 0, 1000, 0, 4095, 65534, 0, -1000, 0, 4095));
        send_pair(make_pair(-131072, -131072, 64, 64, 4095,
                            131071, 131071, -64, -64, 4095));
        drain();
        write_contact(settings[1]);
        send_pair(make_pair(0, 0, 64, 0, 640, 1, 0, -64, 0, 640));
        drain();
        write_contact(settings[2]);
        send_pair(make_pair(0, 0, 64, 0, 640, 1, 0, -64, 0, 640));
        send_pair(make_pair(0, 0, 64, 0, 640, 1, 1, -64, 0, 640));
        drain();

        write_contact(CD_RESET);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_contact(settings[ph - 1]);
            for (int n = 0; n < 75; n++) send_pair(random_pair(sb.contact_dist));
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("disc_pair_elastic_collision_core verification clean");
        end else begin
            $display("disc_pair_elastic_collision_core verification failed");
        end
        $finish;
    end
endmodule
